// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the XMODEM-1K receiver RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define XM1K_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define XM1K_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define XM1K_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XM1K_ASSERT(label, clk, rstn, prop, msg)
`define XM1K_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define XM1K_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/xm1k_pkg.sv =====
// Package for the XMODEM-1K CRC receiver: payload types, protocol codes, CRC step.
// No dependencies.
`timescale 1ns / 1ps

package xm1k_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } xm1k_in_t;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [18:0] data_offset;
        logic        packet_accepted;
        logic [2:0]  status;
        logic [19:0] received_total;
    } xm1k_out_t;

    typedef enum logic [1:0] {
        EV_START   = 2'd0,
        EV_BYTE    = 2'd1,
        EV_TIMEOUT = 2'd2,
        EV_NONE    = 2'd3
    } xm1k_ev_kind_t;

    typedef struct packed {
        xm1k_ev_kind_t kind;
        logic [7:0]    rx_byte;
        logic          is_open;
        logic          is_long;
        logic          is_eot;
        logic          is_cancel;
    } xm1k_event_t;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_START = 8'b0000_0010,
        PH_WAIT  = 8'b0000_0100,
        PH_SEQ   = 8'b0000_1000,
        PH_COMP  = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_CRCH  = 8'b0100_0000,
        PH_CRCL  = 8'b1000_0000
    } xm1k_phase_t;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_C   = 8'h43;
    localparam logic [7:0] B_CAN = 8'h1A;

    localparam logic [2:0] STAT_BUSY       = 3'd0;
    localparam logic [2:0] STAT_SUCCESS    = 3'd1;
    localparam logic [2:0] STAT_START_FAIL = 3'd2;
    localparam logic [2:0] STAT_SEQ_ERR    = 3'd3;
    localparam logic [2:0] STAT_CRC_ERR    = 3'd4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 1'b1;

    localparam logic [19:0] IMAGE_SPACE        = 20'd524288;
    localparam logic [19:0] RESET_IMAGE_LENGTH = 20'd524288;
    localparam logic [7:0]  RESET_RETRY_LIMIT  = 8'd100;
    localparam logic [7:0]  SEQ_SUM            = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0] data_in);
        logic [15:0] crc;
        crc = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/xm1k_front.sv =====
// Front end of the XMODEM-1K receiver: takes requests, decodes them into events
// and holds them in a short queue for the back end. Depends on xm1k_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xm1k_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  xm1k_pkg::xm1k_in_t    s_data,
    output logic                  q_valid,
    input  logic                  q_pop,
    output xm1k_pkg::xm1k_event_t q_event
);

    xm1k_pkg::xm1k_event_t          ev;
    xm1k_pkg::xm1k_event_t          queue_mem [xm1k_pkg::Q_DEPTH];
    logic [xm1k_pkg::Q_PTR_W-1:0]   head_reg, head_next;
    logic [xm1k_pkg::Q_PTR_W-1:0]   tail_reg, tail_next;
    logic [xm1k_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                           push;

    always_comb begin
        ev = '0;
        ev.rx_byte = s_data.rx_byte;
        case (s_data.command)
            xm1k_pkg::CMD_START:   ev.kind = xm1k_pkg::EV_START;
            xm1k_pkg::CMD_BYTE:    ev.kind = xm1k_pkg::EV_BYTE;
            xm1k_pkg::CMD_TIMEOUT: ev.kind = xm1k_pkg::EV_TIMEOUT;
            default:               ev.kind = xm1k_pkg::EV_NONE;
        endcase
        ev.is_open   = s_data.rx_byte inside {xm1k_pkg::B_SOH, xm1k_pkg::B_STX};
        ev.is_long   = (s_data.rx_byte == xm1k_pkg::B_STX);
        ev.is_eot    = (s_data.rx_byte == xm1k_pkg::B_EOT);
        ev.is_cancel = (s_data.rx_byte == xm1k_pkg::B_CAN);
    end

    assign s_ready = (count_reg != xm1k_pkg::Q_CNT_W'(xm1k_pkg::Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_event = queue_mem[head_reg];

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = tail_reg + 1'b1;
        end
        if (q_pop) begin
            head_next = head_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[tail_reg] <= ev;
        end
    end

    `XM1K_ASSERT(a_q_bound, aclk, aresetn, count_reg <= xm1k_pkg::Q_CNT_W'(xm1k_pkg::Q_DEPTH), "queue count above depth")
    `XM1K_ASSERT_IMPLY(a_q_pop_nonempty, aclk, aresetn, q_pop, count_reg != '0, "pop from empty queue")
    `XM1K_ASSERT_NEXT(a_q_fill, aclk, aresetn, push && !q_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not advance on push")

endmodule

// ===== rtl/core/xm1k_back.sv =====
// Back end of the XMODEM-1K receiver: protocol state machine, CRC, offsets and
// the result register. Depends on xm1k_pkg; fed by xm1k_front.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xm1k_back #(
    parameter int SHORT_PACKET = 128,
    parameter int LONG_PACKET  = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  xm1k_pkg::xm1k_event_t               q_event,
    output logic                                m_valid,
    input  logic                                m_ready,
    output xm1k_pkg::xm1k_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [xm1k_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [xm1k_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(LONG_PACKET + 1);
    localparam logic [IDX_W-1:0] SIZE_SHORT = IDX_W'(SHORT_PACKET);
    localparam logic [IDX_W-1:0] SIZE_LONG  = IDX_W'(LONG_PACKET);

    logic [19:0]           image_length_reg;
    logic [7:0]            retry_limit_reg;

    xm1k_pkg::xm1k_phase_t phase_reg, phase_next;
    logic [7:0]            retry_reg, retry_next;
    logic [7:0]            last_seq_reg, last_seq_next;
    logic [7:0]            seq_reg, seq_next;
    logic [7:0]            comp_reg, comp_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  long_reg, long_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            crc_high_reg, crc_high_next;
    logic [19:0]           committed_reg, committed_next;
    logic [19:0]           remaining_reg, remaining_next;
    logic [2:0]            status_reg, status_next;

    logic                  m_valid_reg, m_valid_next;
    xm1k_pkg::xm1k_out_t   m_data_reg, res;

    logic                  got;
    logic [7:0]            retry_inc;
    logic [IDX_W-1:0]      size;
    logic [IDX_W-1:0]      idx_inc;
    logic [19:0]           wr;
    logic [8:0]            seq_sum;
    logic [15:0]           rx_crc;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign got       = (q_event.kind == xm1k_pkg::EV_BYTE);
    assign retry_inc = retry_reg + 8'd1;
    assign size      = long_reg ? SIZE_LONG : SIZE_SHORT;
    assign idx_inc   = idx_reg + 1'b1;
    assign wr        = (remaining_reg > 20'(size)) ? 20'(size) : remaining_reg;
    assign seq_sum   = {1'b0, seq_reg} + {1'b0, comp_reg};
    assign rx_crc    = {crc_high_reg, q_event.rx_byte};

    always_comb begin
        phase_next     = phase_reg;
        retry_next     = retry_reg;
        last_seq_next  = last_seq_reg;
        seq_next       = seq_reg;
        comp_next      = comp_reg;
        idx_next       = idx_reg;
        long_next      = long_reg;
        crc_next       = crc_reg;
        crc_high_next  = crc_high_reg;
        committed_next = committed_reg;
        remaining_next = remaining_reg;
        status_next    = status_reg;
        res            = '0;

        case (q_event.kind)
            xm1k_pkg::EV_START: begin
                retry_next     = '0;
                last_seq_next  = '0;
                committed_next = '0;
                remaining_next = (image_length_reg > xm1k_pkg::IMAGE_SPACE) ?
                                 xm1k_pkg::IMAGE_SPACE : image_length_reg;
                status_next    = xm1k_pkg::STAT_BUSY;
                phase_next     = xm1k_pkg::PH_START;
                res.reply_valid = 1'b1;
                res.reply_byte  = xm1k_pkg::B_C;
            end
            xm1k_pkg::EV_BYTE, xm1k_pkg::EV_TIMEOUT: begin
                case (phase_reg)
                    xm1k_pkg::PH_START: begin
                        retry_next = retry_inc;
                        if (retry_inc == retry_limit_reg || (got && q_event.is_cancel)) begin
                            status_next = xm1k_pkg::STAT_START_FAIL;
                            phase_next  = xm1k_pkg::PH_IDLE;
                        end else if (got && q_event.is_open) begin
                            long_next  = q_event.is_long;
                            idx_next   = '0;
                            crc_next   = '0;
                            phase_next = xm1k_pkg::PH_SEQ;
                        end else if (got && q_event.is_eot) begin
                            res.reply_valid = 1'b1;
                            res.reply_byte  = xm1k_pkg::B_ACK;
                            status_next     = xm1k_pkg::STAT_SUCCESS;
                            phase_next      = xm1k_pkg::PH_IDLE;
                        end else begin
                            res.reply_valid = 1'b1;
                            res.reply_byte  = xm1k_pkg::B_C;
                        end
                    end
                    xm1k_pkg::PH_WAIT: begin
                        if (got && q_event.is_open) begin
                            long_next  = q_event.is_long;
                            idx_next   = '0;
                            crc_next   = '0;
                            phase_next = xm1k_pkg::PH_SEQ;
                        end else if (got && q_event.is_eot) begin
                            res.reply_valid = 1'b1;
                            res.reply_byte  = xm1k_pkg::B_ACK;
                            status_next     = xm1k_pkg::STAT_SUCCESS;
                            phase_next      = xm1k_pkg::PH_IDLE;
                        end
                    end
                    xm1k_pkg::PH_SEQ: begin
                        if (got) begin
                            seq_next   = q_event.rx_byte;
                            phase_next = xm1k_pkg::PH_COMP;
                        end
                    end
                    xm1k_pkg::PH_COMP: begin
                        if (got) begin
                            comp_next  = q_event.rx_byte;
                            phase_next = xm1k_pkg::PH_DATA;
                        end
                    end
                    xm1k_pkg::PH_DATA: begin
                        if (got) begin
                            crc_next = xm1k_pkg::crc16_step(crc_reg, q_event.rx_byte);
                            if (20'(idx_reg) < remaining_reg) begin
                                res.data_valid  = 1'b1;
                                res.data_byte   = q_event.rx_byte;
                                res.data_offset = 19'(committed_reg + 20'(idx_reg));
                            end
                            idx_next = idx_inc;
                            if (idx_inc >= size) begin
                                phase_next = xm1k_pkg::PH_CRCH;
                            end
                        end
                    end
                    xm1k_pkg::PH_CRCH: begin
                        if (got) begin
                            crc_high_next = q_event.rx_byte;
                            phase_next    = xm1k_pkg::PH_CRCL;
                        end
                    end
                    xm1k_pkg::PH_CRCL: begin
                        if (got) begin
                            res.reply_valid = 1'b1;
                            if (seq_sum != {1'b0, xm1k_pkg::SEQ_SUM} ||
                                seq_reg != last_seq_reg + 8'd1) begin
                                res.reply_byte = xm1k_pkg::B_NAK;
                                status_next    = xm1k_pkg::STAT_SEQ_ERR;
                                phase_next     = xm1k_pkg::PH_IDLE;
                            end else if (rx_crc != crc_reg) begin
                                res.reply_byte = xm1k_pkg::B_NAK;
                                status_next    = xm1k_pkg::STAT_CRC_ERR;
                                phase_next     = xm1k_pkg::PH_IDLE;
                            end else begin
                                committed_next      = committed_reg + wr;
                                remaining_next      = remaining_reg - wr;
                                last_seq_next       = seq_reg;
                                res.reply_byte      = xm1k_pkg::B_ACK;
                                res.packet_accepted = 1'b1;
                                phase_next          = xm1k_pkg::PH_WAIT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        res.status         = status_next;
        res.received_total = committed_next;

        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_length_reg <= xm1k_pkg::RESET_IMAGE_LENGTH;
            retry_limit_reg  <= xm1k_pkg::RESET_RETRY_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                xm1k_pkg::REG_IMAGE_LENGTH: image_length_reg <= cfg_wdata[19:0];
                xm1k_pkg::REG_RETRY_LIMIT:  retry_limit_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= xm1k_pkg::PH_IDLE;
            retry_reg     <= '0;
            last_seq_reg  <= '0;
            seq_reg       <= '0;
            comp_reg      <= '0;
            idx_reg       <= '0;
            long_reg      <= 1'b0;
            crc_reg       <= '0;
            crc_high_reg  <= '0;
            committed_reg <= '0;
            remaining_reg <= '0;
            status_reg    <= xm1k_pkg::STAT_BUSY;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                retry_reg     <= retry_next;
                last_seq_reg  <= last_seq_next;
                seq_reg       <= seq_next;
                comp_reg      <= comp_next;
                idx_reg       <= idx_next;
                long_reg      <= long_next;
                crc_reg       <= crc_next;
                crc_high_reg  <= crc_high_next;
                committed_reg <= committed_next;
                remaining_reg <= remaining_next;
                status_reg    <= status_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= res;
        end
    end

    `XM1K_ASSERT_IMPLY(a_accept_is_ack, aclk, aresetn, m_valid_reg && m_data_reg.packet_accepted, m_data_reg.reply_byte == xm1k_pkg::B_ACK && m_data_reg.status == xm1k_pkg::STAT_BUSY, "accepted packet not answered with ACK")
    `XM1K_ASSERT_IMPLY(a_data_no_reply, aclk, aresetn, m_valid_reg && m_data_reg.data_valid, !m_data_reg.reply_valid, "payload byte and reply in one result")
    `XM1K_ASSERT_IMPLY(a_idx_in_packet, aclk, aresetn, phase_reg == xm1k_pkg::PH_DATA, idx_reg < size, "byte index past packet end")

endmodule

// ===== rtl/core/xmodem_1k_crc_receiver_top.sv =====
// XMODEM-1K CRC-16 receiver, top level: takes one request per cycle while the queue has
// room (start, received byte, timeout) and gives exactly one result per request: the
// reply byte to send, a tentative payload byte with its image offset, a packet commit
// flag, the transfer status and the committed byte count. The sustained rate is one
// request per clock while the result side is ready; the front decoder writes a
// four-entry queue and the back end state machine, which updates the CRC with one
// byte per cycle unless stalled, drains it into a single result register, so a
// request's result reaches the result port through the queue and the result register
// and is taken when the result side is ready. Write image_length and start_retry_limit
// only while no request is in flight. Depends on xm1k_pkg, xm1k_front and xm1k_back.
`timescale 1ns / 1ps

module xmodem_1k_crc_receiver_top #(
    parameter int SHORT_PACKET = 128,
    parameter int LONG_PACKET  = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  xm1k_pkg::xm1k_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output xm1k_pkg::xm1k_out_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [xm1k_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xm1k_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                  q_valid;
    logic                  q_pop;
    xm1k_pkg::xm1k_event_t q_event;

    xm1k_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_event (q_event)
    );

    xm1k_back #(
        .SHORT_PACKET (SHORT_PACKET),
        .LONG_PACKET  (LONG_PACKET)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_event   (q_event),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== sim/xmodem_1k_crc_receiver_top_tb.sv =====
// Self-checking testbench for the XMODEM-1K CRC receiver top level: directed events, then
// random transfers with packets, noise and faults under several register settings.
// Depends on xm1k_pkg and xmodem_1k_crc_receiver_top.
`timescale 1ns / 1ps

module xmodem_1k_crc_receiver_top_tb;
    import xm1k_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 60;
    localparam int REPORT_MAX     = 10;
    localparam int LONG_TAIL      = 20;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    xm1k_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    xm1k_out_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    xmodem_1k_crc_receiver_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register copies
    logic [19:0] set_image_len = RESET_IMAGE_LENGTH;
    logic [7:0]  set_retry_lim = RESET_RETRY_LIMIT;

    // receiver state copy
    xm1k_phase_t st_phase     = PH_IDLE;
    logic [7:0]  st_retries   = '0;
    logic [7:0]  st_last_seq  = '0;
    logic [7:0]  st_seq       = '0;
    logic [7:0]  st_comp      = '0;
    logic [10:0] st_index     = '0;
    logic        st_long      = 1'b0;
    logic [15:0] st_crc       = '0;
    logic [7:0]  st_crc_hi    = '0;
    logic [19:0] st_committed = '0;
    logic [19:0] st_remaining = '0;
    logic [2:0]  st_status    = STAT_BUSY;

    xm1k_in_t  pending_req[$];
    xm1k_out_t outcome_q[$];
    xm1k_out_t want;

    int  send_idle_pct  = 12;
    int  recv_idle_pct  = 81;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    int  stall_cycles   = 0;
    int  errors         = 0;
    int  reported       = 0;
    int  accepted_reqs  = 0;
    int  checked_res    = 0;
    int  commits_seen   = 0;
    int  queued_total   = 0;
    int  item_cap       = 2147483647;
    int  transfers      = 0;
    int  settings_run   = 1;
    bit  long_next      = 1'b0;

    function automatic logic [15:0] crc16_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        int          k;
        r = c ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void open_frame(input logic [7:0] b);
        st_long  = (b == B_STX);
        st_index = '0;
        st_crc   = '0;
        st_phase = PH_SEQ;
    endfunction

    function automatic xm1k_out_t receiver_step(input xm1k_in_t req);
        xm1k_out_t   o;
        logic        got;
        logic [10:0] size;
        logic [19:0] take;
        o    = '0;
        got  = (req.command == CMD_BYTE);
        size = st_long ? 11'd1024 : 11'd128;
        if (req.command == CMD_START) begin
            st_retries   = '0;
            st_last_seq  = '0;
            st_committed = '0;
            st_remaining = (set_image_len > IMAGE_SPACE) ? IMAGE_SPACE : set_image_len;
            st_status    = STAT_BUSY;
            st_phase     = PH_START;
            o.reply_valid = 1'b1;
            o.reply_byte  = B_C;
        end else if (req.command == CMD_BYTE || req.command == CMD_TIMEOUT) begin
            case (st_phase)
                PH_START: begin
                    st_retries = st_retries + 8'd1;
                    if (st_retries == set_retry_lim || (got && req.rx_byte == B_CAN)) begin
                        st_status = STAT_START_FAIL;
                        st_phase  = PH_IDLE;
                    end else if (got && (req.rx_byte == B_SOH || req.rx_byte == B_STX)) begin
                        open_frame(req.rx_byte);
                    end else if (got && req.rx_byte == B_EOT) begin
                        o.reply_valid = 1'b1;
                        o.reply_byte  = B_ACK;
                        st_status     = STAT_SUCCESS;
                        st_phase      = PH_IDLE;
                    end else begin
                        o.reply_valid = 1'b1;
                        o.reply_byte  = B_C;
                    end
                end
                PH_WAIT: begin
                    if (got && (req.rx_byte == B_SOH || req.rx_byte == B_STX)) begin
                        open_frame(req.rx_byte);
                    end else if (got && req.rx_byte == B_EOT) begin
                        o.reply_valid = 1'b1;
                        o.reply_byte  = B_ACK;
                        st_status     = STAT_SUCCESS;
                        st_phase      = PH_IDLE;
                    end
                end
                PH_SEQ: begin
                    if (got) begin
                        st_seq   = req.rx_byte;
                        st_phase = PH_COMP;
                    end
                end
                PH_COMP: begin
                    if (got) begin
                        st_comp  = req.rx_byte;
                        st_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (got) begin
                        st_crc = crc16_add(st_crc, req.rx_byte);
                        if ({9'd0, st_index} < st_remaining) begin
                            o.data_valid  = 1'b1;
                            o.data_byte   = req.rx_byte;
                            o.data_offset = st_committed[18:0] + {8'd0, st_index};
                        end
                        st_index = st_index + 11'd1;
                        if (st_index >= size) st_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    if (got) begin
                        st_crc_hi = req.rx_byte;
                        st_phase  = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    if (got) begin
                        o.reply_valid = 1'b1;
                        if (({1'b0, st_seq} + {1'b0, st_comp}) != {1'b0, SEQ_SUM} ||
                            st_seq != st_last_seq + 8'd1) begin
                            o.reply_byte = B_NAK;
                            st_status    = STAT_SEQ_ERR;
                            st_phase     = PH_IDLE;
                        end else if ({st_crc_hi, req.rx_byte} != st_crc) begin
                            o.reply_byte = B_NAK;
                            st_status    = STAT_CRC_ERR;
                            st_phase     = PH_IDLE;
                        end else begin
                            take = (st_remaining > {9'd0, size}) ? {9'd0, size} : st_remaining;
                            st_committed = st_committed + take;
                            st_remaining = st_remaining - take;
                            st_last_seq  = st_seq;
                            o.reply_byte      = B_ACK;
                            o.packet_accepted = 1'b1;
                            st_phase          = PH_WAIT;
                        end
                    end
                end
                default: ;
            endcase
        end
        o.status         = st_status;
        o.received_total = st_committed;
        return o;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_req.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q.push_back(receiver_step(s_data));
                accepted_reqs++;
            end
            if (m_valid && m_ready) begin
                checked_res++;
                if (outcome_q.size() == 0) begin
                    errors++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("unexpected result %0d: status=%0d total=%0d", checked_res,
                                 m_data.status, m_data.received_total);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (want.packet_accepted) commits_seen++;
                    if (m_data.reply_valid !== want.reply_valid ||
                        m_data.reply_byte !== want.reply_byte ||
                        m_data.data_valid !== want.data_valid ||
                        m_data.data_byte !== want.data_byte ||
                        m_data.data_offset !== want.data_offset ||
                        m_data.packet_accepted !== want.packet_accepted ||
                        m_data.status !== want.status ||
                        m_data.received_total !== want.received_total) begin
                        errors++;
                        if (reported < REPORT_MAX) begin
                            reported++;
                            $display("mismatch at result %0d: expected rv=%0d rb=%02h dv=%0d db=%02h off=%0d acc=%0d st=%0d tot=%0d",
                                     checked_res, want.reply_valid, want.reply_byte,
                                     want.data_valid, want.data_byte, want.data_offset,
                                     want.packet_accepted, want.status, want.received_total);
                            $display("    actual rv=%0d rb=%02h dv=%0d db=%02h off=%0d acc=%0d st=%0d tot=%0d",
                                     m_data.reply_valid, m_data.reply_byte, m_data.data_valid,
                                     m_data.data_byte, m_data.data_offset,
                                     m_data.packet_accepted, m_data.status,
                                     m_data.received_total);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] cmd, input logic [7:0] b);
        xm1k_in_t r;
        if (queued_total < item_cap) begin
            r.command = cmd;
            r.rx_byte = b;
            pending_req.push_back(r);
            queued_total++;
        end
    endtask

    function automatic logic [7:0] filler_byte(input bit allow_cancel);
        logic [7:0] b;
        b = 8'($urandom);
        while (b == B_SOH || b == B_STX || b == B_EOT || (!allow_cancel && b == B_CAN)) begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    task automatic queue_filler(input bit allow_cancel);
        if ($urandom_range(1)) begin
            push_req(CMD_TIMEOUT, 8'($urandom));
        end else begin
            push_req(CMD_BYTE, filler_byte(allow_cancel));
        end
    endtask

    task automatic queue_packet(input int seq, output bit broken);
        int          fault;
        int          size;
        int          i;
        logic [7:0]  sq;
        logic [7:0]  cp;
        logic [7:0]  b;
        logic [15:0] crc;
        bit          long_pkt;
        long_pkt  = long_next || ($urandom_range(99) < 3);
        long_next = 1'b0;
        size      = long_pkt ? 1024 : 128;
        push_req(CMD_BYTE, long_pkt ? B_STX : B_SOH);
        sq    = 8'(seq);
        fault = $urandom_range(99);
        if (fault < 4) sq = sq + 8'($urandom_range(1, 255));
        cp = ~sq;
        if (fault >= 4 && fault < 8) cp = cp ^ (8'd1 << $urandom_range(7));
        push_req(CMD_BYTE, sq);
        push_req(CMD_BYTE, cp);
        crc = '0;
        for (i = 0; i < size; i++) begin
            b   = 8'($urandom);
            crc = crc16_add(crc, b);
            push_req(CMD_BYTE, b);
            if ($urandom_range(99) < 2) begin
                push_req($urandom_range(1) ? CMD_TIMEOUT : EV_NONE, 8'($urandom));
            end
        end
        if (fault >= 8 && fault < 12) crc = crc ^ (16'd1 << $urandom_range(15));
        push_req(CMD_BYTE, crc[15:8]);
        push_req(CMD_BYTE, crc[7:0]);
        broken = (fault < 12);
    endtask

    task automatic queue_transfer();
        int kind;
        int lim;
        int nfill;
        int npk;
        int k;
        int seq;
        bit broken;
        transfers++;
        lim  = (set_retry_lim == 8'd0) ? 256 : int'(set_retry_lim);
        kind = long_next ? 0 : $urandom_range(99);
        if (kind < 72) begin
            push_req(CMD_START, 8'($urandom));
            nfill = $urandom_range(2);
            if (nfill > lim - 2) nfill = (lim > 2) ? lim - 2 : 0;
            for (k = 0; k < nfill; k++) queue_filler(1'b0);
            npk    = $urandom_range(1, 3);
            broken = 1'b0;
            for (seq = 1; seq <= npk && !broken; seq++) begin
                if (seq > 1) begin
                    repeat ($urandom_range(2)) queue_filler(1'b1);
                end
                queue_packet(seq, broken);
            end
            if (!broken && $urandom_range(9) < 8) push_req(CMD_BYTE, B_EOT);
        end else if (kind < 87) begin
            push_req(CMD_START, 8'($urandom));
            if ($urandom_range(1)) begin
                nfill = $urandom_range(3);
                if (nfill > lim - 2) nfill = (lim > 2) ? lim - 2 : 0;
                for (k = 0; k < nfill; k++) queue_filler(1'b0);
                push_req(CMD_BYTE, B_CAN);
            end else begin
                for (k = 0; k < lim - 1; k++) queue_filler(1'b0);
                case ($urandom_range(3))
                    0: push_req(CMD_TIMEOUT, 8'($urandom));
                    1: push_req(CMD_BYTE, B_SOH);
                    2: push_req(CMD_BYTE, B_STX);
                    default: push_req(CMD_BYTE, B_EOT);
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 4)) push_req(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    task automatic build_traffic(input int budget);
        int goal;
        goal     = queued_total + budget;
        item_cap = goal;
        while (queued_total < goal) queue_transfer();
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_req.size() != 0 || s_valid || outcome_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_LENGTH) begin
            set_image_len = val;
        end else begin
            set_retry_lim = val[7:0];
        end
    endtask

    task automatic configure(input logic [19:0] img, input logic [7:0] lim);
        wait_drained();
        repeat (6) @(posedge aclk);
        write_reg(REG_IMAGE_LENGTH, img);
        write_reg(REG_RETRY_LIMIT, {12'd0, lim});
        settings_run++;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [19:0] img, input logic [7:0] lim, input int sp,
                             input int rp, input int budget, input bit force_long);
        int first;
        first = force_long ? budget - LONG_TAIL : budget / 2;
        configure(img, lim);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        long_next     = force_long;
        build_traffic(first);
        // stall the result side while requests keep coming
        repeat (5) @(negedge aclk);
        hold_requests++;
        // hold the sender until everything is back
        wait_drained();
        build_traffic(budget - first);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle events, start attempts, cancel, end of transmission, restarts
        push_req(CMD_BYTE, 8'hFF);
        push_req(CMD_TIMEOUT, 8'h00);
        push_req(EV_NONE, 8'hAA);
        push_req(CMD_START, 8'h00);
        push_req(CMD_TIMEOUT, 8'hFF);
        push_req(CMD_BYTE, 8'h00);
        push_req(CMD_BYTE, 8'hFF);
        push_req(CMD_BYTE, B_CAN);
        push_req(CMD_START, 8'h55);
        push_req(CMD_BYTE, B_EOT);
        push_req(CMD_START, 8'h00);
        push_req(CMD_START, 8'hFF);
        push_req(CMD_BYTE, B_STX);
        push_req(CMD_BYTE, 8'h01);
        push_req(CMD_BYTE, 8'hFE);
        push_req(CMD_TIMEOUT, 8'h00);
        push_req(CMD_BYTE, 8'hFF);
        push_req(CMD_BYTE, 8'h00);
        push_req(EV_NONE, 8'h00);
        push_req(CMD_START, 8'h00);
        push_req(CMD_BYTE, B_EOT);

        // attempt limit: a start byte on the last attempt still fails
        configure(20'd100, 8'd2);
        push_req(CMD_START, 8'h00);
        push_req(CMD_TIMEOUT, 8'h00);
        push_req(CMD_BYTE, B_SOH);

        run_phase(20'd300, 8'd5, 12, 81, 300, 1'b0);
        run_phase(IMAGE_SPACE, 8'd255, 12, 81, 1100, 1'b1);
        run_phase(20'd0, 8'd1, 81, 12, 15, 1'b0);
        run_phase(20'hFFFFF, 8'd0, 81, 12, 15, 1'b0);
        run_phase(20'($urandom_range(1, 2000)), 8'($urandom_range(2, 20)), 0, 0, 15, 1'b0);
        run_phase(20'd1024, RESET_RETRY_LIMIT, 0, 0, 15, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (outcome_q.size() != 0) begin
            errors += outcome_q.size();
            $display("%0d expected results never arrived", outcome_q.size());
        end
        $display("run covered %0d requests and %0d results in %0d transfers over %0d settings",
                 accepted_reqs, checked_res, transfers, settings_run);
        $display("%0d packets committed, %0d mismatches", commits_seen, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/xm1k_pkg.sv
rtl/core/xm1k_front.sv
rtl/core/xm1k_back.sv
rtl/core/xmodem_1k_crc_receiver_top.sv
sim/xmodem_1k_crc_receiver_top_tb.sv
